[design/acss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acss_pkg
// Shared widths, codes and types for the adc channel scan sequencer.
// ----------------------------------------------------------------------------
package acss_pkg;

  localparam int unsigned ChanW   = 5;
  localparam int unsigned FromW   = ChanW + 1;
  localparam int unsigned SampleW = 12;
  localparam int unsigned SlipW   = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned MaskW   = 31;

  typedef enum logic [StatusW-1:0] {
    ST_STARTED    = 3'd0,
    ST_SLIP       = 3'd1,
    ST_NO_CHAN    = 3'd2,
    ST_SAMPLE     = 3'd3,
    ST_UNEXPECTED = 3'd4
  } status_e;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_DONE = 1'b1
  } mode_e;

  // result of the next-channel search
  typedef struct packed {
    logic             found;
    logic [ChanW-1:0] chan;
  } chan_hit_t;

endpackage
`default_nettype wire

[design/acss_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acss_if
// Valid/ready channels for event words in and result words out.
// ----------------------------------------------------------------------------
interface acss_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [acss_pkg::SampleW-1:0]  sample_in;

  modport source (output valid, output mode, output sample_in, input ready);
  modport sink   (input valid, input mode, input sample_in, output ready);
endinterface

interface acss_out_if;
  logic                          valid;
  logic                          ready;
  logic [acss_pkg::StatusW-1:0]  status;
  logic                          start_valid;
  logic [acss_pkg::ChanW-1:0]    start_chan;
  logic                          sample_valid;
  logic [acss_pkg::ChanW-1:0]    sample_chan;
  logic [acss_pkg::SampleW-1:0]  sample_out;
  logic [acss_pkg::SlipW-1:0]    slip_total;

  modport source (output valid, output status, output start_valid, output start_chan,
                  output sample_valid, output sample_chan, output sample_out,
                  output slip_total, input ready);
  modport sink   (input valid, input status, input start_valid, input start_chan,
                  input sample_valid, input sample_chan, input sample_out,
                  input slip_total, output ready);
endinterface
`default_nettype wire

[design/adc_channel_scan_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_channel_scan_sequencer
// Walks the enabled adc channels in ascending order on scan ticks and
// conversion completions, tags samples and counts scan slips.
// ----------------------------------------------------------------------------
//   port      dir  handshake    word
//   in_i      in   valid/ready  mode, sample_in
//   out_o     out  valid/ready  status, start/sample fields, slip_total
//   cfg_*     in   write enable channel_enable_mask
//
// one word per cycle sustained while out_o is ready; an accepted word passes
// the input register, then the result register, on its way to out_o
// the next-channel search is a single priority encoder over the mask
// reset clears scan state, slip counter and mask; no clearing pass
// a stalled out_o keeps its word and in_i still takes one more word
// ----------------------------------------------------------------------------
module adc_channel_scan_sequencer #(
  parameter int unsigned NUM_CHANNELS = 31,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  acss_in_if.sink                          in_i,
  acss_out_if.source                       out_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [acss_pkg::MaskW-1:0]  cfg_wdata_i
);

  localparam int unsigned LiveW =
    (NUM_CHANNELS > acss_pkg::MaskW) ? acss_pkg::MaskW : NUM_CHANNELS;
  localparam logic [acss_pkg::MaskW-1:0] LiveMask =
    acss_pkg::MaskW'((64'd1 << LiveW) - 64'd1);

  logic [acss_pkg::MaskW-1:0]    mask_q;
  logic [acss_pkg::MaskW-1:0]    live_mask;
  logic                          take;
  logic                          item_vld;
  logic                          item_mode;
  logic [acss_pkg::SampleW-1:0]  item_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  assign live_mask = mask_q & LiveMask;

  acss_in_stage #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_in_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .take_i   (take),
    .vld_o    (item_vld),
    .mode_o   (item_mode),
    .sample_o (item_sample)
  );

  acss_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_vld_i    (item_vld),
    .item_mode_i   (item_mode),
    .item_sample_i (item_sample),
    .live_mask_i   (live_mask),
    .take_o        (take),
    .out_o         (out_o)
  );

endmodule
`default_nettype wire

[design/acss_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acss_in_stage
// Input register: holds one event word until the core takes it.
// ----------------------------------------------------------------------------
module acss_in_stage #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  acss_in_if.sink                           in_i,
  input  wire logic                         take_i,
  output logic                              vld_o,
  output logic                              mode_o,
  output logic [acss_pkg::SampleW-1:0]      sample_o
);

  localparam int unsigned SmpW =
    (SAMPLE_BITS > acss_pkg::SampleW) ? acss_pkg::SampleW : SAMPLE_BITS;
  localparam logic [acss_pkg::SampleW-1:0] SmpMask =
    acss_pkg::SampleW'((32'd1 << SmpW) - 32'd1);

  logic                          vld_q, vld_d;
  logic                          mode_q;
  logic [acss_pkg::SampleW-1:0]  sample_q;
  logic                          load;

  assign in_i.ready = !vld_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q   <= in_i.mode;
      sample_q <= in_i.sample_in & SmpMask;
    end
  end

  assign vld_o    = vld_q;
  assign mode_o   = mode_q;
  assign sample_o = sample_q;

endmodule
`default_nettype wire

[design/acss_chan_find.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acss_chan_find
// Priority encoder: lowest enabled channel at or above a start channel.
// ----------------------------------------------------------------------------
module acss_chan_find (
  input  wire logic [acss_pkg::MaskW-1:0]  mask_i,
  input  wire logic [acss_pkg::FromW-1:0]  from_i,
  output acss_pkg::chan_hit_t              hit_o
);

  always_comb begin
    hit_o = '0;
    // scan downward so the lowest qualifying bit wins
    for (int i = acss_pkg::MaskW - 1; i >= 0; i--) begin
      if (mask_i[i] && (acss_pkg::FromW'(i) >= from_i)) begin
        hit_o.found = 1'b1;
        hit_o.chan  = acss_pkg::ChanW'(i);
      end
    end
  end

endmodule
`default_nettype wire

[design/acss_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acss_core
// Scan state, per-event decision and the result register.
// ----------------------------------------------------------------------------
module acss_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         item_vld_i,
  input  wire logic                         item_mode_i,
  input  wire logic [acss_pkg::SampleW-1:0] item_sample_i,
  input  wire logic [acss_pkg::MaskW-1:0]   live_mask_i,
  output logic                              take_o,
  acss_out_if.source                        out_o
);

  logic                          busy_q, busy_d;
  logic [acss_pkg::ChanW-1:0]    cur_q, cur_d;
  logic [acss_pkg::SlipW-1:0]    slip_q, slip_d;
  logic                          ovld_q, ovld_d;

  acss_pkg::status_e             status_d;
  logic                          start_vld_d;
  logic [acss_pkg::ChanW-1:0]    start_chan_d;
  logic                          smp_vld_d;
  logic [acss_pkg::ChanW-1:0]    smp_chan_d;
  logic [acss_pkg::SampleW-1:0]  smp_d;

  logic [acss_pkg::StatusW-1:0]  status_q;
  logic                          start_vld_q;
  logic [acss_pkg::ChanW-1:0]    start_chan_q;
  logic                          smp_vld_q;
  logic [acss_pkg::ChanW-1:0]    smp_chan_q;
  logic [acss_pkg::SampleW-1:0]  smp_q;
  logic [acss_pkg::SlipW-1:0]    slip_out_q;

  logic [acss_pkg::FromW-1:0]    from;
  acss_pkg::chan_hit_t           hit;

  assign take_o = item_vld_i && (!ovld_q || out_o.ready);

  // a tick searches from channel 0, a completion from the channel above
  assign from = (item_mode_i == acss_pkg::MODE_DONE) ?
                ({1'b0, cur_q} + acss_pkg::FromW'(1)) : '0;

  acss_chan_find u_find (
    .mask_i (live_mask_i),
    .from_i (from),
    .hit_o  (hit)
  );

  always_comb begin
    busy_d       = busy_q;
    cur_d        = cur_q;
    slip_d       = slip_q;
    status_d     = acss_pkg::ST_UNEXPECTED;
    start_vld_d  = 1'b0;
    start_chan_d = '0;
    smp_vld_d    = 1'b0;
    smp_chan_d   = '0;
    smp_d        = '0;
    if (item_mode_i == acss_pkg::MODE_TICK) begin
      if (live_mask_i == '0) begin
        status_d = acss_pkg::ST_NO_CHAN;
      end else if (busy_q) begin
        slip_d   = slip_q + acss_pkg::SlipW'(1);
        status_d = acss_pkg::ST_SLIP;
      end else begin
        cur_d        = hit.chan;
        busy_d       = 1'b1;
        start_vld_d  = 1'b1;
        start_chan_d = hit.chan;
        status_d     = acss_pkg::ST_STARTED;
      end
    end else if (busy_q) begin
      smp_vld_d  = 1'b1;
      smp_chan_d = cur_q;
      smp_d      = item_sample_i;
      status_d   = acss_pkg::ST_SAMPLE;
      if (hit.found) begin
        cur_d        = hit.chan;
        start_vld_d  = 1'b1;
        start_chan_d = hit.chan;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_comb begin
    ovld_d = ovld_q;
    if (take_o) begin
      ovld_d = 1'b1;
    end else if (out_o.ready) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cur_q  <= '0;
      slip_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      ovld_q <= ovld_d;
      if (take_o) begin
        busy_q <= busy_d;
        cur_q  <= cur_d;
        slip_q <= slip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      status_q     <= status_d;
      start_vld_q  <= start_vld_d;
      start_chan_q <= start_chan_d;
      smp_vld_q    <= smp_vld_d;
      smp_chan_q   <= smp_chan_d;
      smp_q        <= smp_d;
      slip_out_q   <= slip_d;
    end
  end

  assign out_o.valid        = ovld_q;
  assign out_o.status       = status_q;
  assign out_o.start_valid  = start_vld_q;
  assign out_o.start_chan   = start_chan_q;
  assign out_o.sample_valid = smp_vld_q;
  assign out_o.sample_chan  = smp_chan_q;
  assign out_o.sample_out   = smp_q;
  assign out_o.slip_total   = slip_out_q;

endmodule
`default_nettype wire

[dv/adc_channel_scan_sequencer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_channel_scan_sequencer_test
// Self-checking bench for the channel scan sequencer. Scan ticks and
// conversion completions go in over the event channel under random
// idling and backpressure. Enable masks are changed between phases, a
// long output stall fills the pipeline, and a burst of ticks piles up
// slips under a running scan. A scoreboard predicts every result word and
// compares it field by field.
// ----------------------------------------------------------------------------
module adc_channel_scan_sequencer_test;

  localparam logic [acss_pkg::MaskW-1:0] ALL_CHANNELS = '1;
  localparam int               NUM_PHASES   = 12;
  localparam int               PHASE_WORDS  = 68;
  localparam int               PRESS_PHASE  = 5;
  localparam int               LONG_HOLD    = 150;
  localparam int               SLIP_TICKS   = 20;

  typedef struct packed {
    acss_pkg::status_e                status;
    logic                             start_valid;
    logic [acss_pkg::ChanW-1:0]       start_chan;
    logic                             sample_valid;
    logic [acss_pkg::ChanW-1:0]       sample_chan;
    logic [acss_pkg::SampleW-1:0]     sample_out;
    logic [acss_pkg::SlipW-1:0]       slip_total;
  } scan_result_t;

  class scan_scoreboard;
    logic [acss_pkg::MaskW-1:0] mask  = '0;
    bit                         busy  = 1'b0;
    logic [acss_pkg::ChanW-1:0] chan  = '0;
    logic [acss_pkg::SlipW-1:0] slips = '0;
    scan_result_t               pending_results[$];
    int                         mismatches = 0;
    int                         status_seen[5];

    // lowest enabled channel at or above from_chan
    function bit find_enabled(input int from_chan,
                              output logic [acss_pkg::ChanW-1:0] hit);
      hit = '0;
      for (int i = from_chan; i < acss_pkg::MaskW; i++) begin
        if (mask[i]) begin
          hit = acss_pkg::ChanW'(i);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void predict_scan_step(input acss_pkg::mode_e m,
                                    input logic [acss_pkg::SampleW-1:0] s);
      scan_result_t               r;
      logic [acss_pkg::ChanW-1:0] nxt;
      r = '0;
      if (m == acss_pkg::MODE_TICK) begin
        if (mask == '0) begin
          r.status = acss_pkg::ST_NO_CHAN;
        end else if (busy) begin
          slips    = slips + acss_pkg::SlipW'(1);
          r.status = acss_pkg::ST_SLIP;
        end else begin
          void'(find_enabled(0, nxt));
          chan          = nxt;
          busy          = 1'b1;
          r.start_valid = 1'b1;
          r.start_chan  = chan;
          r.status      = acss_pkg::ST_STARTED;
        end
      end else if (!busy) begin
        r.status = acss_pkg::ST_UNEXPECTED;
      end else begin
        r.sample_valid = 1'b1;
        r.sample_chan  = chan;
        r.sample_out   = s;
        r.status       = acss_pkg::ST_SAMPLE;
        if (find_enabled(int'(chan) + 1, nxt)) begin
          chan          = nxt;
          r.start_valid = 1'b1;
          r.start_chan  = chan;
        end else begin
          busy = 1'b0;
        end
      end
      r.slip_total = slips;
      status_seen[int'(r.status)]++;
      pending_results.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(input scan_result_t got);
      scan_result_t want;
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: status %0d", got.status);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("start_valid", 32'(want.start_valid), 32'(got.start_valid));
      compare_field("start_chan", 32'(want.start_chan), 32'(got.start_chan));
      compare_field("sample_valid", 32'(want.sample_valid), 32'(got.sample_valid));
      compare_field("sample_chan", 32'(want.sample_chan), 32'(got.sample_chan));
      compare_field("sample_out", 32'(want.sample_out), 32'(got.sample_out));
      compare_field("slip_total", 32'(want.slip_total), 32'(got.slip_total));
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we;
  logic [acss_pkg::MaskW-1:0] cfg_wdata;
  bit               tx_idle_en    = 1'b1;
  bit               rx_idle_en    = 1'b1;
  bit               long_hold_req = 1'b0;
  int               words_sent    = 0;
  int               mask_writes   = 0;

  scan_scoreboard sb = new;

  acss_in_if  in_ch ();
  acss_out_if out_ch ();

  adc_channel_scan_sequencer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // mostly no gap, some short ones, a few long
  function automatic int pick_gap(input bit en);
    int r;
    r = $urandom_range(0, 99);
    if (!en || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input acss_pkg::mode_e m,
                           input logic [acss_pkg::SampleW-1:0] s);
    int gap;
    gap = pick_gap(tx_idle_en);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.sample_in <= s;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.predict_scan_step(m, s);
    words_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_mask(input logic [acss_pkg::MaskW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.mask = v;
    mask_writes++;
  endtask

  function automatic logic [acss_pkg::MaskW-1:0] pick_mask(input int p);
    case (p % 8)
      0: return ALL_CHANNELS;
      1: return '0;
      2: return acss_pkg::MaskW'(1);
      3: return acss_pkg::MaskW'(1) << (acss_pkg::MaskW - 1);
      4: return acss_pkg::MaskW'($urandom);
      5: return acss_pkg::MaskW'($urandom & $urandom & $urandom);
      6: return acss_pkg::MaskW'(1) << $urandom_range(0, acss_pkg::MaskW - 1);
      default: return acss_pkg::MaskW'($urandom | 32'h4000_0001);
    endcase
  endfunction

  // result side: checks each accepted word and plays backpressure
  initial begin : result_sink
    int           hold;
    scan_result_t got;
    hold = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got.status       = acss_pkg::status_e'(out_ch.status);
        got.start_valid  = out_ch.start_valid;
        got.start_chan   = out_ch.start_chan;
        got.sample_valid = out_ch.sample_valid;
        got.sample_chan  = out_ch.sample_chan;
        got.sample_out   = out_ch.sample_out;
        got.slip_total   = out_ch.slip_total;
        sb.check_result(got);
      end
      if (hold > 0) begin
        hold--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold          = LONG_HOLD;
      end else begin
        hold = pick_gap(rx_idle_en);
      end
      out_ch.ready <= (hold == 0);
    end
  end

  initial begin : stimulus
    acss_pkg::mode_e m;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= acss_pkg::MODE_TICK;
    in_ch.sample_in <= '0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    rst_ni          <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty mask after reset: tick and completion are both turned away
    send_word(acss_pkg::MODE_TICK, '0);
    send_word(acss_pkg::MODE_DONE, '1);
    drain_results();
    // lowest and highest channel, slip while busy, completion while idle
    write_mask(acss_pkg::MaskW'(32'h4000_0001));
    send_word(acss_pkg::MODE_TICK, '0);
    send_word(acss_pkg::MODE_TICK, '1);
    send_word(acss_pkg::MODE_DONE, '1);
    send_word(acss_pkg::MODE_DONE, '0);
    send_word(acss_pkg::MODE_DONE, 12'h5a5);
    // mask moved under a running scan: next channel from the new mask
    send_word(acss_pkg::MODE_TICK, '0);
    drain_results();
    write_mask(acss_pkg::MaskW'(1) << 5);
    send_word(acss_pkg::MODE_DONE, 12'h0f0);
    drain_results();
    // nothing left above the current channel: scan ends
    write_mask(acss_pkg::MaskW'(1) << 2);
    send_word(acss_pkg::MODE_DONE, 12'hf0f);
    send_word(acss_pkg::MODE_TICK, '0);
    drain_results();
    // empty mask while busy: no slip counted
    write_mask('0);
    send_word(acss_pkg::MODE_TICK, 12'h123);
    drain_results();
    write_mask(acss_pkg::MaskW'(1) << 2);
    send_word(acss_pkg::MODE_DONE, 12'habc);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_mask(pick_mask(p));
      tx_idle_en = (p % 3 != 0);
      rx_idle_en = (p % 3 != 0);
      if (p == PRESS_PHASE) begin
        // sender keeps offering while the result side holds off
        tx_idle_en    = 1'b0;
        long_hold_req = 1'b1;
      end
      repeat (PHASE_WORDS) begin
        if (sb.busy) begin
          m = ($urandom_range(0, 99) < 85) ? acss_pkg::MODE_DONE : acss_pkg::MODE_TICK;
        end else begin
          m = ($urandom_range(0, 99) < 85) ? acss_pkg::MODE_TICK : acss_pkg::MODE_DONE;
        end
        send_word(m, acss_pkg::SampleW'($urandom_range(0, 4095)));
      end
      drain_results();
    end

    // slip burst under a running scan
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_mask(ALL_CHANNELS);
    if (!sb.busy) send_word(acss_pkg::MODE_TICK, '0);
    repeat (SLIP_TICKS) begin
      send_word(acss_pkg::MODE_TICK, acss_pkg::SampleW'($urandom_range(0, 4095)));
    end
    rx_idle_en = 1'b1;
    repeat (4) send_word(acss_pkg::MODE_DONE, acss_pkg::SampleW'($urandom_range(0, 4095)));
    drain_results();
    repeat (10) @(posedge clk_i);

    $display("covered %0d words over %0d mask writes: %0d scans, %0d samples, %0d slips",
             words_sent, mask_writes, sb.status_seen[acss_pkg::ST_STARTED],
             sb.status_seen[acss_pkg::ST_SAMPLE], sb.status_seen[acss_pkg::ST_SLIP]);
    $display("%0d ticks with no channel, %0d completions while idle, slip count %0d",
             sb.status_seen[acss_pkg::ST_NO_CHAN], sb.status_seen[acss_pkg::ST_UNEXPECTED],
             sb.slips);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #(50_000_000);
    $display("run timed out, %0d results pending", sb.pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

[adc_channel_scan_sequencer.f]
design/acss_pkg.sv
design/acss_if.sv
design/acss_in_stage.sv
design/acss_chan_find.sv
design/acss_core.sv
design/adc_channel_scan_sequencer.sv
dv/adc_channel_scan_sequencer_test.sv
